### src/btow_pkg.sv
`timescale 1ns / 1ps
// types and constants shared by the binary tree order walk modules
package btow_pkg;

	localparam int IDX_W   = 5;
	localparam int LINK_W  = 6;
	localparam int PHASE_W = 2;
	localparam int FRAME_W = 7;
	localparam int CNT_W   = 6;

	localparam logic [CNT_W-1:0] MAX_RESULTS = 6'd32;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_WALK = 1'b1;

	localparam logic [PHASE_W-1:0] PHASE_LEFT  = 2'd0;
	localparam logic [PHASE_W-1:0] PHASE_RIGHT = 2'd1;
	localparam logic [PHASE_W-1:0] PHASE_DONE  = 2'd2;

	localparam logic [PHASE_W-1:0] ORDER_PRE  = 2'd0;
	localparam logic [PHASE_W-1:0] ORDER_IN   = 2'd1;
	localparam logic [PHASE_W-1:0] ORDER_POST = 2'd2;
	localparam logic [PHASE_W-1:0] ORDER_NONE = 2'd3;

	typedef struct packed {
		logic               op;
		logic [IDX_W-1:0]   node_index;
		logic               left_present;
		logic [IDX_W-1:0]   left_index;
		logic               right_present;
		logic [IDX_W-1:0]   right_index;
		logic [PHASE_W-1:0] walk_order;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] visited_node;
		logic             last;
		logic             overflow;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load_wr;
		logic walk_start;
		logic link_rd;
		logic visit;
		logic push;
		logic adv_phase;
		logic pop_rd;
		logic pop_load;
		logic set_stop;
		logic fin_emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic               phase_match;
		logic               count_full;
		logic               pend_valid;
		logic               out_free;
		logic               has_child;
		logic               stack_full;
		logic               last_frame;
		logic [PHASE_W-1:0] top_phase;
	} status_t;

endpackage

### src/btow_ctrl.sv
`timescale 1ns / 1ps
// walk controller state machine
module btow_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  btow_pkg::in_item_t in_data,
	input  btow_pkg::status_t  status,
	output btow_pkg::cmd_t     cmd
);
	import btow_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_EVAL   = 3'd2;
	localparam logic [2:0] ST_POP    = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_next;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_data.op == OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else if (in_data.walk_order != ORDER_NONE) begin
						cmd.walk_start = 1'b1;
						state_next     = ST_READ;
					end
				end
			end
			ST_READ: begin
				cmd.link_rd = 1'b1;
				state_next  = ST_EVAL;
			end
			ST_EVAL: begin
				priority if (status.phase_match && status.count_full) begin
					cmd.set_stop = 1'b1;
					state_next   = ST_FINISH;
				end else if (status.phase_match && status.pend_valid && !status.out_free) begin
					// wait for the output register to drain
					state_next = ST_EVAL;
				end else begin
					cmd.visit = status.phase_match;
					if (status.top_phase == PHASE_LEFT || status.top_phase == PHASE_RIGHT) begin
						if (status.has_child) begin
							if (status.stack_full) begin
								cmd.set_stop = 1'b1;
								state_next   = ST_FINISH;
							end else begin
								cmd.push   = 1'b1;
								state_next = ST_READ;
							end
						end else begin
							cmd.adv_phase = 1'b1;
						end
					end else begin
						if (status.last_frame) begin
							state_next = ST_FINISH;
						end else begin
							cmd.pop_rd = 1'b1;
							state_next = ST_POP;
						end
					end
				end
			end
			ST_POP: begin
				cmd.pop_load = 1'b1;
				state_next   = ST_READ;
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.fin_emit = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

### src/btow_dp.sv
`timescale 1ns / 1ps
// link tables, frame stack, top frame and output register
module btow_dp #(
	parameter int NODES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  btow_pkg::in_item_t  in_data,
	input  btow_pkg::cmd_t      cmd,
	output btow_pkg::status_t   status,
	output logic                out_valid,
	input  logic                out_ready,
	output btow_pkg::out_item_t out_data
);
	import btow_pkg::*;

	localparam int AW = $clog2(NODES);
	localparam int DW = $clog2(NODES + 1);

	logic [LINK_W-1:0]  left_mem  [NODES];
	logic [LINK_W-1:0]  right_mem [NODES];
	logic [FRAME_W-1:0] stack_mem [NODES];

	logic [LINK_W-1:0]  left_rd_q;
	logic [LINK_W-1:0]  right_rd_q;
	logic [FRAME_W-1:0] stack_rd_q;

	logic [IDX_W-1:0]   top_node_q;
	logic [PHASE_W-1:0] top_phase_q;
	logic [PHASE_W-1:0] order_q;
	logic [IDX_W-1:0]   pend_node_q;
	logic               pend_valid_q;
	logic [DW-1:0]      depth_q;
	logic [CNT_W-1:0]   count_q;
	logic               stopped_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	logic              load_in_range;
	logic [DW-1:0]     depth_m1;
	logic [DW-1:0]     depth_m2;
	logic [LINK_W-1:0] sel_link;
	logic              out_free;
	logic              out_load;

	assign load_in_range = (32'(in_data.node_index) < NODES);
	assign depth_m1      = depth_q - DW'(1);
	assign depth_m2      = depth_q - DW'(2);
	assign sel_link      = (top_phase_q == PHASE_LEFT) ? left_rd_q : right_rd_q;
	assign out_free      = !out_valid_q || out_ready;
	assign out_load      = (cmd.visit && pend_valid_q) || cmd.fin_emit;

	// memories with registered reads
	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_in_range) begin
			left_mem[AW'(in_data.node_index)]  <= {in_data.left_present, in_data.left_index};
			right_mem[AW'(in_data.node_index)] <= {in_data.right_present, in_data.right_index};
		end
		if (cmd.link_rd) begin
			left_rd_q  <= left_mem[AW'(top_node_q)];
			right_rd_q <= right_mem[AW'(top_node_q)];
		end
		if (cmd.push) begin
			stack_mem[depth_m1[AW-1:0]] <= {top_phase_q + 2'd1, top_node_q};
		end
		if (cmd.pop_rd) begin
			stack_rd_q <= stack_mem[depth_m2[AW-1:0]];
		end
	end

	// top frame, pending visit and output payload
	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			order_q     <= in_data.walk_order;
			top_node_q  <= '0;
			top_phase_q <= PHASE_LEFT;
		end else if (cmd.push) begin
			top_node_q  <= sel_link[IDX_W-1:0];
			top_phase_q <= PHASE_LEFT;
		end else if (cmd.adv_phase) begin
			top_phase_q <= top_phase_q + 2'd1;
		end else if (cmd.pop_load) begin
			top_phase_q <= stack_rd_q[FRAME_W-1:IDX_W];
			top_node_q  <= stack_rd_q[IDX_W-1:0];
		end
		if (cmd.visit) begin
			pend_node_q <= top_node_q;
		end
		if (cmd.fin_emit) begin
			if (pend_valid_q) begin
				out_data_q <= '{visited_node: pend_node_q, last: 1'b1, overflow: stopped_q};
			end else begin
				out_data_q <= '{visited_node: '0, last: 1'b1, overflow: 1'b1};
			end
		end else if (cmd.visit && pend_valid_q) begin
			out_data_q <= '{visited_node: pend_node_q, last: 1'b0, overflow: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= '0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			stopped_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.walk_start) begin
				depth_q      <= DW'(1);
				count_q      <= '0;
				pend_valid_q <= 1'b0;
				stopped_q    <= 1'b0;
			end else begin
				if (cmd.fin_emit) begin
					depth_q <= '0;
				end else if (cmd.push) begin
					depth_q <= depth_q + DW'(1);
				end else if (cmd.pop_rd) begin
					depth_q <= depth_m1;
				end
				if (cmd.visit) begin
					count_q <= count_q + CNT_W'(1);
				end
				if (cmd.fin_emit) begin
					pend_valid_q <= 1'b0;
				end else if (cmd.visit) begin
					pend_valid_q <= 1'b1;
				end
				if (cmd.set_stop) begin
					stopped_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.phase_match = (top_phase_q == order_q);
	assign status.count_full  = (count_q >= MAX_RESULTS);
	assign status.pend_valid  = pend_valid_q;
	assign status.out_free    = out_free;
	assign status.has_child   = sel_link[LINK_W-1] && (32'(sel_link[IDX_W-1:0]) < NODES);
	assign status.stack_full  = (32'(depth_q) >= NODES);
	assign status.last_frame  = (depth_q == DW'(1));
	assign status.top_phase   = top_phase_q;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(depth_q) <= NODES)
		else $error("stack depth above node count");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_RESULTS)
		else $error("visit count above result limit");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (32'(depth_q) < NODES))
		else $error("push onto a full stack");
	a_out_no_clobber: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free)
		else $error("output register overwritten while held");
	a_depth_zero_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin_emit |=> (depth_q == '0) && !pend_valid_q)
		else $error("walk did not unwind");
`endif

endmodule

### src/binary_tree_order_walk_top.sv
`timescale 1ns / 1ps
// binary tree order walk: child-link table load and pre/in/post-order walk
// usage:
//   in_valid/in_ready carry one input transaction. op = load writes the left
//   and right links of node_index and produces nothing. op = walk
//   walks from node 0 in the order given by walk_order and returns one output
//   transaction per visited node on out_valid/out_ready; the last one has
//   last = 1, and overflow = 1 on it when the walk stopped early (stack full
//   or more than 32 visits). walk_order 3 produces nothing.
// sequencing:
//   a walk steps each reachable node through its left, right and done
//   phases, with a registered read of the link tables each time the walk
//   moves to another node and of the frame stack on each pop. a visit
//   leaves the block once the next visit or the end of the walk is known.
//   in_ready is high only between walks, so one item is in work at a time.
// reset:
//   arst_n clears the controller, stack depth and output valid; link entries
//   hold nothing until loaded and are not cleared.
// stalls:
//   when out_ready is low with a result held, the walk holds at the next visit
//   or at its end until the output register drains; no result is dropped.
module binary_tree_order_walk_top #(
	parameter int NODES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  btow_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output btow_pkg::out_item_t out_data
);
	import btow_pkg::*;

	cmd_t    cmd;
	status_t status;

	btow_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.status   (status),
		.cmd      (cmd)
	);

	btow_dp #(
		.NODES (NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
